// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the roi clipping auto exposure block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define RCAE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rcae assertion failed");

// condition in one cycle implies a result in the next
`define RCAE_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("rcae assertion failed");

`endif

// ----- src/rcae_pkg.sv -----
// ----------------------------------------------------------------------------
// rcae_pkg
// types and constants of the roi clipping auto exposure block
// ----------------------------------------------------------------------------
package rcae_pkg;

   localparam int COORD_BITS_DEF  = 12;
   localparam int SAMPLE_BITS_DEF = 10;

   localparam int CENTER_BITS  = 12;
   localparam int RADIUS_BITS  = 11;
   localparam int SAT_BITS     = 10;
   localparam int PCT_BITS     = 7;
   localparam int EXP_BITS     = 8;
   localparam int FRAC_BITS    = 16;
   localparam int EXP_FIX_BITS = EXP_BITS + FRAC_BITS;
   localparam int COUNT_BITS   = 25;
   localparam int SCALE_BITS   = 16;
   localparam int PROD_BITS    = COUNT_BITS + PCT_BITS;

   localparam int ACTION_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   localparam int RSP_DATA_BITS  = EXP_BITS + 2 * COUNT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_DATA_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(24'hFFFFFF) + COUNT_BITS'(1);
   localparam logic [SCALE_BITS-1:0] SCALE_095 = 16'd62259;
   localparam logic [PCT_BITS-1:0]   PCT_FULL  = 7'd100;

   localparam logic [CENTER_BITS-1:0] CENTER_RESET  = '0;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET  = '0;
   localparam logic [SAT_BITS-1:0]    SAT_RESET     = 10'd1023;
   localparam logic [PCT_BITS-1:0]    PCT_RESET     = 7'd1;
   localparam logic [EXP_BITS-1:0]    MAX_EXP_RESET = 8'd100;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PIXEL     = 2'd0,
      ACT_END_FRAME = 2'd1,
      ACT_START     = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_X     = 3'd0,
      REG_CENTER_Y     = 3'd1,
      REG_RADIUS       = 3'd2,
      REG_SATURATION   = 3'd3,
      REG_ALLOWED_PCT  = 3'd4,
      REG_MAX_EXPOSURE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] region_pixel_count;
      logic [COUNT_BITS-1:0] overexposed_count;
      logic                  accepted;
      logic [EXP_BITS-1:0]   exposure_setting;
   } rsp_word_type;

endpackage

// ----- src/roi_clipping_auto_exposure_core.sv -----
// ----------------------------------------------------------------------------
// roi_clipping_auto_exposure_core
// auto exposure search counting overexposed pixels inside a circular region
// ----------------------------------------------------------------------------
// req channel: one word per pixel, end of frame or start of search, kind in
// req_tuser. a start word returns one rsp word with max exposure, an end of
// frame word returns one rsp word with the frame counts and the new exposure
// while a search runs, pixel words return nothing.
// csr channel: register index and data, always ready. registers must be
// written by the user only while idle; the block does not enforce this.
// the three stage pipeline (input register, square stage, counter stage)
// takes one req word per cycle while req_tready is high.
// a four entry output queue holds rsp words; req_tready drops only when
// the queue plus the start and end words in flight would overfill it, so a
// stalled receiver holds back req words only once four results are pending.
// reset: synchronous, clears the pipeline, queue, counters and search flag
// and loads the register reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module roi_clipping_auto_exposure_core #(
   parameter int COORD_BITS  = rcae_pkg::COORD_BITS_DEF,
   parameter int SAMPLE_BITS = rcae_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_DATA_BITS  = 2 * COORD_BITS + 3 * SAMPLE_BITS,
   localparam int REQ_TDATA_BITS = ((REQ_DATA_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel_x, pixel_y, red_value, green_value, blue_value
   input  logic [REQ_TDATA_BITS-1:0]           req_tdata,
   // action
   input  logic [rcae_pkg::ACTION_BITS-1:0]    req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // exposure_setting, overexposed_count, region_pixel_count
   output logic [rcae_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // accepted
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rcae_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rcae_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DIFF_BITS = (COORD_BITS > rcae_pkg::CENTER_BITS) ?
                              COORD_BITS : rcae_pkg::CENTER_BITS;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int SUM_BITS  = SQ_BITS + 1;
   localparam int RSQ_BITS  = 2 * rcae_pkg::RADIUS_BITS;
   localparam int CMP_BITS  = (SAMPLE_BITS > rcae_pkg::SAT_BITS) ?
                              SAMPLE_BITS : rcae_pkg::SAT_BITS;
   localparam int EXP_PROD_BITS = rcae_pkg::EXP_FIX_BITS + rcae_pkg::SCALE_BITS;
   localparam int CNT = rcae_pkg::COUNT_BITS;
   localparam int CRED_BITS = rcae_pkg::FIFO_CNT_BITS + 1;

   function automatic logic [CNT-1:0] sat_inc(input logic [CNT-1:0] c);
      logic [CNT-1:0] r;
      r = (c >= rcae_pkg::COUNT_MAX) ? rcae_pkg::COUNT_MAX : c + CNT'(1);
      return r;
   endfunction

   // configuration registers
   logic [rcae_pkg::CENTER_BITS-1:0] center_x_ff, center_y_ff;
   logic [rcae_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [rcae_pkg::SAT_BITS-1:0]    sat_level_ff;
   logic [rcae_pkg::PCT_BITS-1:0]    allowed_pct_ff;
   logic [rcae_pkg::EXP_BITS-1:0]    max_exp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= rcae_pkg::CENTER_RESET;
         center_y_ff    <= rcae_pkg::CENTER_RESET;
         radius_ff      <= rcae_pkg::RADIUS_RESET;
         sat_level_ff   <= rcae_pkg::SAT_RESET;
         allowed_pct_ff <= rcae_pkg::PCT_RESET;
         max_exp_ff     <= rcae_pkg::MAX_EXP_RESET;
      end else if (csr_valid) begin
         case (rcae_pkg::csr_index_type'(csr_index))
            rcae_pkg::REG_CENTER_X: begin
               center_x_ff <= csr_wdata[rcae_pkg::CENTER_BITS-1:0];
            end
            rcae_pkg::REG_CENTER_Y: begin
               center_y_ff <= csr_wdata[rcae_pkg::CENTER_BITS-1:0];
            end
            rcae_pkg::REG_RADIUS: begin
               radius_ff <= csr_wdata[rcae_pkg::RADIUS_BITS-1:0];
            end
            rcae_pkg::REG_SATURATION: begin
               sat_level_ff <= csr_wdata[rcae_pkg::SAT_BITS-1:0];
            end
            rcae_pkg::REG_ALLOWED_PCT: begin
               allowed_pct_ff <= csr_wdata[rcae_pkg::PCT_BITS-1:0];
            end
            rcae_pkg::REG_MAX_EXPOSURE: begin
               max_exp_ff <= csr_wdata[rcae_pkg::EXP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage 1: input register
   logic                             s1_valid_ff;
   logic [rcae_pkg::ACTION_BITS-1:0] s1_action_ff;
   logic [COORD_BITS-1:0]            s1_x_ff, s1_y_ff;
   logic [SAMPLE_BITS-1:0]           s1_red_ff, s1_green_ff, s1_blue_ff;
   logic                             req_take;

   assign req_take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      s1_action_ff <= req_tuser;
      s1_x_ff      <= req_tdata[COORD_BITS-1:0];
      s1_y_ff      <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      s1_red_ff    <= req_tdata[2*COORD_BITS+SAMPLE_BITS-1:2*COORD_BITS];
      s1_green_ff  <= req_tdata[2*COORD_BITS+2*SAMPLE_BITS-1:2*COORD_BITS+SAMPLE_BITS];
      s1_blue_ff   <= req_tdata[REQ_DATA_BITS-1:2*COORD_BITS+2*SAMPLE_BITS];
   end

   // stage 2: squared distances and overexposure flag
   logic [DIFF_BITS-1:0] px_in, py_in, cx_in, cy_in, dx_in, dy_in;
   logic [CMP_BITS-1:0]  sat_in;
   logic                 hot_in;

   logic                             s2_valid_ff;
   logic [rcae_pkg::ACTION_BITS-1:0] s2_action_ff;
   logic [SQ_BITS-1:0]               s2_dx2_ff, s2_dy2_ff;
   logic [RSQ_BITS-1:0]              s2_r2_ff;
   logic                             s2_hot_ff;

   always_comb begin
      px_in  = DIFF_BITS'(s1_x_ff);
      py_in  = DIFF_BITS'(s1_y_ff);
      cx_in  = DIFF_BITS'(center_x_ff);
      cy_in  = DIFF_BITS'(center_y_ff);
      dx_in  = (cx_in >= px_in) ? cx_in - px_in : px_in - cx_in;
      dy_in  = (cy_in >= py_in) ? cy_in - py_in : py_in - cy_in;
      sat_in = CMP_BITS'(sat_level_ff);
      hot_in = (CMP_BITS'(s1_red_ff) >= sat_in) ||
               (CMP_BITS'(s1_green_ff) >= sat_in) ||
               (CMP_BITS'(s1_blue_ff) >= sat_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_action_ff <= s1_action_ff;
      s2_dx2_ff    <= SQ_BITS'(dx_in) * SQ_BITS'(dx_in);
      s2_dy2_ff    <= SQ_BITS'(dy_in) * SQ_BITS'(dy_in);
      s2_r2_ff     <= RSQ_BITS'(radius_ff) * RSQ_BITS'(radius_ff);
      s2_hot_ff    <= hot_in;
   end

   // stage 3: counters, exposure and result
   logic [rcae_pkg::EXP_FIX_BITS-1:0] exposure_ff, exposure_in;
   logic [CNT-1:0]                    over_cnt_ff, over_cnt_in;
   logic [CNT-1:0]                    region_cnt_ff, region_cnt_in;
   logic                              searching_ff, searching_in;
   logic                              in_region;
   logic [rcae_pkg::PROD_BITS-1:0]    over_x100, region_x_pct;
   logic                              frame_ok;
   logic [EXP_PROD_BITS-1:0]          exp_prod;
   logic [rcae_pkg::EXP_FIX_BITS-1:0] exp_scaled;
   logic                              push;
   rcae_pkg::rsp_word_type            push_word;

   always_comb begin
      in_region    = (SUM_BITS'(s2_dx2_ff) + SUM_BITS'(s2_dy2_ff)) < SUM_BITS'(s2_r2_ff);
      over_x100    = rcae_pkg::PROD_BITS'(over_cnt_ff) *
                     rcae_pkg::PROD_BITS'(rcae_pkg::PCT_FULL);
      region_x_pct = rcae_pkg::PROD_BITS'(region_cnt_ff) *
                     rcae_pkg::PROD_BITS'(allowed_pct_ff);
      frame_ok     = over_x100 <= region_x_pct;
      exp_prod     = EXP_PROD_BITS'(exposure_ff) * EXP_PROD_BITS'(rcae_pkg::SCALE_095);
      exp_scaled   = exp_prod[EXP_PROD_BITS-1:rcae_pkg::FRAC_BITS];

      exposure_in   = exposure_ff;
      over_cnt_in   = over_cnt_ff;
      region_cnt_in = region_cnt_ff;
      searching_in  = searching_ff;
      push          = 1'b0;
      push_word     = '0;

      if (s2_valid_ff) begin
         case (rcae_pkg::action_type'(s2_action_ff))
            rcae_pkg::ACT_PIXEL: begin
               if (searching_ff && in_region) begin
                  region_cnt_in = sat_inc(region_cnt_ff);
                  if (s2_hot_ff) begin
                     over_cnt_in = sat_inc(over_cnt_ff);
                  end
               end
            end
            rcae_pkg::ACT_END_FRAME: begin
               if (searching_ff) begin
                  push                         = 1'b1;
                  push_word.accepted           = frame_ok;
                  push_word.overexposed_count  = over_cnt_ff;
                  push_word.region_pixel_count = region_cnt_ff;
                  over_cnt_in                  = '0;
                  region_cnt_in                = '0;
                  if (frame_ok) begin
                     searching_in = 1'b0;
                     push_word.exposure_setting =
                        exposure_ff[rcae_pkg::EXP_FIX_BITS-1:rcae_pkg::FRAC_BITS];
                  end else begin
                     exposure_in = exp_scaled;
                     push_word.exposure_setting =
                        exp_scaled[rcae_pkg::EXP_FIX_BITS-1:rcae_pkg::FRAC_BITS];
                  end
               end
            end
            rcae_pkg::ACT_START: begin
               exposure_in  = {max_exp_ff, rcae_pkg::FRAC_BITS'(0)};
               over_cnt_in   = '0;
               region_cnt_in = '0;
               searching_in  = 1'b1;
               push          = 1'b1;
               push_word.exposure_setting = max_exp_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff   <= {rcae_pkg::MAX_EXP_RESET, rcae_pkg::FRAC_BITS'(0)};
         over_cnt_ff   <= '0;
         region_cnt_ff <= '0;
         searching_ff  <= 1'b0;
      end else begin
         exposure_ff   <= exposure_in;
         over_cnt_ff   <= over_cnt_in;
         region_cnt_ff <= region_cnt_in;
         searching_ff  <= searching_in;
      end
   end

   // output queue
   rcae_pkg::rsp_word_type               fifo_mem_ff [rcae_pkg::FIFO_DEPTH];
   logic [rcae_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [rcae_pkg::FIFO_CNT_BITS-1:0]   fifo_cnt_ff, fifo_cnt_in;
   logic                                 pop;
   rcae_pkg::rsp_word_type               rsp_word;
   logic                                 s1_result, s2_result;
   logic [CRED_BITS-1:0]                 credit_sum;

   assign pop      = rsp_tvalid && rsp_tready;
   assign rsp_word = fifo_mem_ff[rd_ptr_ff];

   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_tuser  = rsp_word.accepted;
   assign rsp_tdata  = rcae_pkg::RSP_TDATA_BITS'({rsp_word.region_pixel_count,
                                                  rsp_word.overexposed_count,
                                                  rsp_word.exposure_setting});

   assign s1_result = s1_valid_ff &&
                      ((s1_action_ff == rcae_pkg::ACT_END_FRAME) ||
                       (s1_action_ff == rcae_pkg::ACT_START));
   assign s2_result = s2_valid_ff &&
                      ((s2_action_ff == rcae_pkg::ACT_END_FRAME) ||
                       (s2_action_ff == rcae_pkg::ACT_START));
   assign credit_sum = CRED_BITS'(fifo_cnt_ff) + CRED_BITS'(s1_result) +
                       CRED_BITS'(s2_result);
   assign req_tready = credit_sum < CRED_BITS'(rcae_pkg::FIFO_DEPTH);

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (push && !pop) begin
         fifo_cnt_in = fifo_cnt_ff + rcae_pkg::FIFO_CNT_BITS'(1);
      end else if (pop && !push) begin
         fifo_cnt_in = fifo_cnt_ff - rcae_pkg::FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rcae_pkg::FIFO_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + rcae_pkg::FIFO_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   // assertions
   `RCAE_ASSERT_ALWAYS(a_credit_bound, clock, reset,
      credit_sum <= CRED_BITS'(rcae_pkg::FIFO_DEPTH))
   `RCAE_ASSERT_NEXT(a_start_arms, clock, reset,
      s2_valid_ff && (s2_action_ff == rcae_pkg::ACT_START),
      searching_ff && (exposure_ff[rcae_pkg::EXP_FIX_BITS-1:rcae_pkg::FRAC_BITS] == max_exp_ff))
   `RCAE_ASSERT_NEXT(a_pixel_no_word, clock, reset,
      s2_valid_ff && (s2_action_ff == rcae_pkg::ACT_PIXEL) && !pop,
      fifo_cnt_ff == $past(fifo_cnt_ff))
   `RCAE_ASSERT_NEXT(a_accept_ends_search, clock, reset,
      push && push_word.accepted,
      !searching_ff && (over_cnt_ff == '0) && (region_cnt_ff == '0))

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// testbench of roi_clipping_auto_exposure_core: pixel, end of frame and start
// words go in over the req stream, a scoreboard predicts each rsp word from
// its own copy of the counters, exposure and registers, and every rsp word is
// checked field by field in order under random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int REQ_TDATA_W =
      ((2 * rcae_pkg::COORD_BITS_DEF + 3 * rcae_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam logic [rcae_pkg::ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
   localparam int COORD_MAX = (1 << rcae_pkg::COORD_BITS_DEF) - 1;
   localparam int SAMPLE_MAX = (1 << rcae_pkg::SAMPLE_BITS_DEF) - 1;

   typedef struct {
      logic [rcae_pkg::EXP_BITS-1:0]   exposure;
      logic                            accepted;
      logic [rcae_pkg::COUNT_BITS-1:0] over;
      logic [rcae_pkg::COUNT_BITS-1:0] region;
   } exposure_report_type;

   class exposure_scoreboard;
      logic [rcae_pkg::CENTER_BITS-1:0]  center_x;
      logic [rcae_pkg::CENTER_BITS-1:0]  center_y;
      logic [rcae_pkg::RADIUS_BITS-1:0]  radius;
      logic [rcae_pkg::SAT_BITS-1:0]     sat_level;
      logic [rcae_pkg::PCT_BITS-1:0]     allowed_pct;
      logic [rcae_pkg::EXP_BITS-1:0]     max_exp;
      logic [rcae_pkg::EXP_FIX_BITS-1:0] exp_fix;
      logic [rcae_pkg::COUNT_BITS-1:0]   over_cnt;
      logic [rcae_pkg::COUNT_BITS-1:0]   region_cnt;
      bit                                searching;
      exposure_report_type               report_q[$];
      int                                mismatches;
      int                                reports_seen;
      int                                frames_accepted;
      int                                frames_retried;
      int                                reg_writes;

      function new();
         center_x    = rcae_pkg::CENTER_RESET;
         center_y    = rcae_pkg::CENTER_RESET;
         radius      = rcae_pkg::RADIUS_RESET;
         sat_level   = rcae_pkg::SAT_RESET;
         allowed_pct = rcae_pkg::PCT_RESET;
         max_exp     = rcae_pkg::MAX_EXP_RESET;
         exp_fix     = {rcae_pkg::MAX_EXP_RESET, 16'h0000};
         over_cnt    = '0;
         region_cnt  = '0;
         searching   = 1'b0;
      endfunction

      function void write_reg(rcae_pkg::csr_index_type idx,
                              logic [rcae_pkg::CSR_DATA_BITS-1:0] value);
         reg_writes++;
         case (idx)
            rcae_pkg::REG_CENTER_X:     center_x    = value[rcae_pkg::CENTER_BITS-1:0];
            rcae_pkg::REG_CENTER_Y:     center_y    = value[rcae_pkg::CENTER_BITS-1:0];
            rcae_pkg::REG_RADIUS:       radius      = value[rcae_pkg::RADIUS_BITS-1:0];
            rcae_pkg::REG_SATURATION:   sat_level   = value[rcae_pkg::SAT_BITS-1:0];
            rcae_pkg::REG_ALLOWED_PCT:  allowed_pct = value[rcae_pkg::PCT_BITS-1:0];
            rcae_pkg::REG_MAX_EXPOSURE: max_exp     = value[rcae_pkg::EXP_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [rcae_pkg::COUNT_BITS-1:0] bump(logic [rcae_pkg::COUNT_BITS-1:0] c);
         return (c >= rcae_pkg::COUNT_MAX) ? rcae_pkg::COUNT_MAX : c + 1'b1;
      endfunction

      function void note_input(logic [rcae_pkg::ACTION_BITS-1:0] act, logic [11:0] x,
                               logic [11:0] y, logic [9:0] r, logic [9:0] g,
                               logic [9:0] b);
         longint unsigned     dx;
         longint unsigned     dy;
         longint unsigned     lhs;
         longint unsigned     rhs;
         logic [39:0]         prod;
         exposure_report_type rep;
         case (act)
            rcae_pkg::ACT_START: begin
               exp_fix    = {max_exp, 16'h0000};
               over_cnt   = '0;
               region_cnt = '0;
               searching  = 1'b1;
               rep.exposure = max_exp;
               rep.accepted = 1'b0;
               rep.over     = '0;
               rep.region   = '0;
               report_q.push_back(rep);
            end
            rcae_pkg::ACT_PIXEL: begin
               if (searching) begin
                  dx = (center_x >= x) ? center_x - x : x - center_x;
                  dy = (center_y >= y) ? center_y - y : y - center_y;
                  if (dx * dx + dy * dy < longint'(radius) * longint'(radius)) begin
                     region_cnt = bump(region_cnt);
                     if (r >= sat_level || g >= sat_level || b >= sat_level)
                        over_cnt = bump(over_cnt);
                  end
               end
            end
            rcae_pkg::ACT_END_FRAME: begin
               if (searching) begin
                  lhs = longint'(over_cnt) * 100;
                  rhs = longint'(region_cnt) * longint'(allowed_pct);
                  rep.accepted = (lhs <= rhs);
                  if (rep.accepted) begin
                     searching = 1'b0;
                     frames_accepted++;
                  end else begin
                     prod    = 40'(exp_fix) * 40'(rcae_pkg::SCALE_095);
                     exp_fix = prod[39:16];
                     frames_retried++;
                  end
                  rep.exposure = exp_fix[rcae_pkg::EXP_FIX_BITS-1:rcae_pkg::FRAC_BITS];
                  rep.over     = over_cnt;
                  rep.region   = region_cnt;
                  report_q.push_back(rep);
                  over_cnt   = '0;
                  region_cnt = '0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [rcae_pkg::RSP_TDATA_BITS-1:0] tdata, logic tuser);
         exposure_report_type want;
         exposure_report_type got;
         got.exposure = tdata[7:0];
         got.over     = tdata[32:8];
         got.region   = tdata[57:33];
         got.accepted = tuser;
         reports_seen++;
         if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected word: exp %0d acc %0d over %0d region %0d",
                        $realtime, got.exposure, got.accepted, got.over, got.region);
         end else begin
            want = report_q.pop_front();
            if (got.exposure !== want.exposure || got.accepted !== want.accepted ||
                got.over !== want.over || got.region !== want.region) begin
               mismatches++;
               if (mismatches <= 10)
                  $display(
                     "%0t mismatch exp/acc/over/region: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, want.exposure, want.accepted, want.over, want.region,
                     got.exposure, got.accepted, got.over, got.region);
            end
         end
      endfunction

      function int pending();
         return report_q.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic [REQ_TDATA_W-1:0]              req_tdata = '0;
   logic [rcae_pkg::ACTION_BITS-1:0]    req_tuser = rcae_pkg::ACT_PIXEL;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [rcae_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [rcae_pkg::CSR_INDEX_BITS-1:0] csr_index = rcae_pkg::REG_CENTER_X;
   logic [rcae_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   exposure_scoreboard sb = new();
   int send_idle_pct = 35;
   int recv_idle_pct = 80;
   int words_sent = 0;
   int configs_done = 0;

   roi_clipping_auto_exposure_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_word(logic [rcae_pkg::ACTION_BITS-1:0] act, logic [11:0] x,
                            logic [11:0] y, logic [9:0] r, logic [9:0] g, logic [9:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, b, g, r, y, x};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_input(act, x, y, r, g, b);
      words_sent++;
   endtask

   task automatic send_random_word(logic [rcae_pkg::ACTION_BITS-1:0] act);
      send_word(act, 12'($urandom_range(COORD_MAX)), 12'($urandom_range(COORD_MAX)),
                10'($urandom_range(SAMPLE_MAX)), 10'($urandom_range(SAMPLE_MAX)),
                10'($urandom_range(SAMPLE_MAX)));
   endtask

   // hold the sender until every report is back and the pipeline is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(rcae_pkg::csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rcae_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.write_reg(idx, rcae_pkg::CSR_DATA_BITS'(value));
   endtask

   task automatic set_config(int cx, int cy, int rad, int sat, int pct, int mexp);
      drain();
      write_reg(rcae_pkg::REG_CENTER_X, cx);
      write_reg(rcae_pkg::REG_CENTER_Y, cy);
      write_reg(rcae_pkg::REG_RADIUS, rad);
      write_reg(rcae_pkg::REG_SATURATION, sat);
      write_reg(rcae_pkg::REG_ALLOWED_PCT, pct);
      write_reg(rcae_pkg::REG_MAX_EXPOSURE, mexp);
      csr_valid <= 1'b0;
      configs_done++;
   endtask

   task automatic random_config();
      int rad;
      int sat;
      int pct;
      case ($urandom_range(3))
         0: rad = $urandom_range(8);
         1: rad = $urandom_range(64, 9);
         2: rad = $urandom_range(400, 65);
         default: rad = $urandom_range(2047, 401);
      endcase
      case ($urandom_range(4))
         0: sat = 0;
         1: sat = SAMPLE_MAX;
         default: sat = $urandom_range(SAMPLE_MAX);
      endcase
      pct = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(40);
      set_config($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), rad, sat, pct,
                 $urandom_range(255));
   endtask

   function automatic logic [11:0] near_coord(logic [11:0] c, logic [10:0] rad);
      int span;
      int v;
      span = int'(rad) + 3;
      v = int'(c) + int'($urandom_range(2 * span)) - span;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return 12'(v);
   endfunction

   function automatic logic [9:0] pick_sample(bit hot);
      if (hot)
         return 10'($urandom_range(SAMPLE_MAX, sb.sat_level));
      if (sb.sat_level == 0)
         return 10'($urandom_range(SAMPLE_MAX));
      return 10'($urandom_range(sb.sat_level - 1));
   endfunction

   task automatic send_pixel();
      logic [11:0] x;
      logic [11:0] y;
      logic [9:0]  s [3];
      int          hot_ch;
      if ($urandom_range(4) == 0) begin
         send_random_word(rcae_pkg::ACT_PIXEL);
      end else begin
         x = near_coord(sb.center_x, sb.radius);
         y = near_coord(sb.center_y, sb.radius);
         hot_ch = ($urandom_range(3) == 0) ? $urandom_range(2) : -1;
         for (int i = 0; i < 3; i++)
            s[i] = pick_sample(i == hot_ch);
         send_word(rcae_pkg::ACT_PIXEL, x, y, s[0], s[1], s[2]);
      end
   endtask

   // words that never give a report
   task automatic send_noise();
      if (!sb.searching && $urandom_range(1) == 0)
         send_random_word($urandom_range(1) ? rcae_pkg::ACT_PIXEL :
                                              rcae_pkg::ACT_END_FRAME);
      else
         send_random_word(ACT_UNUSED);
   endtask

   task automatic run_search();
      int frames;
      int pixels;
      send_random_word(rcae_pkg::ACT_START);
      frames = $urandom_range(6, 1);
      for (int f = 0; f < frames && sb.searching; f++) begin
         pixels = ($urandom_range(5) == 0) ? 0 : $urandom_range(14, 1);
         for (int p = 0; p < pixels; p++) begin
            send_pixel();
            if ($urandom_range(19) == 0)
               send_random_word(ACT_UNUSED);
         end
         send_random_word(rcae_pkg::ACT_END_FRAME);
      end
   endtask

   task automatic random_phase(int quota);
      int stop_at;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         if ($urandom_range(6) == 0)
            send_noise();
         else
            run_search();
      end
   endtask

   task automatic directed_words();
      // reset registers: empty region, idle block
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd0, 12'd0, 10'd1023, 10'd1023, 10'd1023);
      send_word(ACT_UNUSED, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF, 10'h3FF);
      send_word(rcae_pkg::ACT_START, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd0, 12'd0, 10'd1023, 10'd1023, 10'd1023);
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      // widest region, zero saturation, share above a hundred percent
      set_config(2048, 2048, 2047, 0, 127, 255);
      send_word(rcae_pkg::ACT_START, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd0, 12'd0, 10'd1023, 10'd1023, 10'd1023);
      send_word(rcae_pkg::ACT_PIXEL, 12'hFFF, 12'hFFF, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd2048, 12'd2048, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'hFFF, 12'd2048, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd4094, 12'd2048, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      // zero max exposure with zero allowed share
      set_config(100, 100, 10, 1023, 0, 0);
      send_word(rcae_pkg::ACT_START, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd100, 12'd100, 10'd1023, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      // share exactly at the limit, then above it
      set_config(100, 100, 10, 1000, 50, 1);
      send_word(rcae_pkg::ACT_START, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd100, 12'd100, 10'd0, 10'd0, 10'd1000);
      send_word(rcae_pkg::ACT_PIXEL, 12'd101, 12'd100, 10'd999, 10'd999, 10'd999);
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_START, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd100, 12'd100, 10'd0, 10'd1023, 10'd0);
      send_word(rcae_pkg::ACT_PIXEL, 12'd99, 12'd99, 10'd1000, 10'd0, 10'd0);
      send_word(rcae_pkg::ACT_END_FRAME, 12'd0, 12'd0, 10'd0, 10'd0, 10'd0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 35;
      recv_idle_pct = 80;
      directed_words();
      for (int k = 0; k < 3; k++) begin
         random_config();
         random_phase(45);
      end

      send_idle_pct = 80;
      recv_idle_pct = 35;
      set_config(COORD_MAX, COORD_MAX, 2047, SAMPLE_MAX, 100, 255);
      random_phase(45);
      for (int k = 0; k < 2; k++) begin
         random_config();
         random_phase(45);
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(0, 0, 0, 0, 0, 0);
      random_phase(45);
      for (int k = 0; k < 3; k++) begin
         random_config();
         random_phase(45);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("sent %0d words in %0d register settings (%0d register writes)",
               words_sent, configs_done, sb.reg_writes);
      $display("checked %0d reports: %0d frames accepted, %0d frames retried",
               sb.reports_seen, sb.frames_accepted, sb.frames_retried);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d reports missing", sb.mismatches, sb.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
